>>> sv/framed_command_decoder_defines.svh
// Assertion macros shared by the checker files of the framed command decoder.
`ifndef FRAMED_COMMAND_DECODER_DEFINES_SVH
`define FRAMED_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define FCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define FCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/fcd_pkg.sv
// Package with the constants, codes and types of the framed command decoder.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

   // Frame size limit and the widths that follow from it.
   localparam int FRAME_CAP = 128;
   localparam int COUNT_W   = $clog2(FRAME_CAP);
   localparam int HEAD_LEN  = 12;
   localparam int LEN_W     = 7;
   localparam int LEN_EXT_W = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;
   localparam int LEN_MAX   = 127;
   localparam int WORD_LEN  = 3;
   localparam int RGB_LEN   = 12;
   localparam int COLOR_MAX = 255;

   typedef logic [COUNT_W-1:0] count_type;

   // Command codes of a result word.
   typedef enum logic [3:0] {
      CMD_ALT      = 4'd0,
      CMD_PES      = 4'd1,
      CMD_RGB      = 4'd2,
      CMD_RGB_ON   = 4'd3,
      CMD_RGB_OFF  = 4'd4,
      CMD_NEON_ON  = 4'd5,
      CMD_NEON_OFF = 4'd6,
      CMD_FORWARD  = 4'd7,
      CMD_UNKNOWN  = 4'd8
   } cmd_type;

   // Characters that the decoder looks for.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_DIG0   = 8'h30;
   localparam logic [7:0] CHAR_DIG1   = 8'h31;
   localparam logic [7:0] CHAR_DIG9   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_E      = 8'h45;
   localparam logic [7:0] CHAR_F      = 8'h46;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_L      = 8'h4C;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_T      = 8'h54;

   // What the frame tracker shows of the open frame.
   typedef struct packed {
      count_type                  text_len;
      logic [HEAD_LEN-1:0][7:0]   head;
   } frame_view_type;

   // One result word.
   typedef struct packed {
      cmd_type          command;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [LEN_W-1:0] text_length;
   } result_type;

endpackage

`default_nettype wire

>>> sv/fcd_channels.sv
// Valid/ready channel interfaces for the request bytes and the result words.
`timescale 1ns / 1ps
`default_nettype none

interface fcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcd_rsp_if;
   import fcd_pkg::*;

   logic             valid;
   logic             ready;
   logic [3:0]       command;
   logic [7:0]       red;
   logic [7:0]       green;
   logic [7:0]       blue;
   logic [LEN_W-1:0] text_length;

   modport source (output valid, output command, output red, output green, output blue,
                   output text_length, input ready);
   modport sink   (input valid, input command, input red, input green, input blue,
                   input text_length, output ready);
endinterface

`default_nettype wire

>>> sv/fcd_frame_tracker.sv
// Frame state: open flag, byte count, text length and the first text characters.
`timescale 1ns / 1ps
`default_nettype none

module fcd_frame_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output fcd_pkg::frame_view_type view,
   output logic                  close
);
   import fcd_pkg::*;

   logic                     inside_ff, inside_in;
   count_type                count_ff, count_in;
   logic                     zero_ff, zero_in;
   count_type                len_ff, len_in;
   logic [HEAD_LEN-1:0][7:0] head_ff, head_in;

   // A '$' closes the frame only when one is open.
   assign close = inside_ff && (rx_byte == CHAR_DOLLAR);

   // Head entries at or above the text length are never looked at, so they
   // need no clearing when a frame starts.
   assign view.text_len = len_ff;
   assign view.head     = head_ff;

   // Next frame state for the word being processed.
   always_comb begin
      inside_in = inside_ff;
      count_in  = count_ff;
      zero_in   = zero_ff;
      len_in    = len_ff;
      head_in   = head_ff;
      if (step) begin
         if (rx_byte == CHAR_HASH) begin
            inside_in = 1'b1;
            count_in  = '0;
            zero_in   = 1'b0;
            len_in    = '0;
         end else if (inside_ff) begin
            if (rx_byte == CHAR_DOLLAR || count_ff >= COUNT_W'(FRAME_CAP - 1)) begin
               // Frame closed or dropped for overflow.
               inside_in = 1'b0;
               count_in  = '0;
               zero_in   = 1'b0;
               len_in    = '0;
            end else begin
               if (!zero_ff) begin
                  if (rx_byte == CHAR_NUL) begin
                     zero_in = 1'b1;
                  end else begin
                     for (int i = 0; i < HEAD_LEN; i++) begin
                        if (len_ff == COUNT_W'(i)) begin
                           head_in[i] = rx_byte;
                        end
                     end
                     len_in = len_ff + 1'b1;
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         count_ff  <= '0;
         zero_ff   <= 1'b0;
         len_ff    <= '0;
      end else begin
         inside_ff <= inside_in;
         count_ff  <= count_in;
         zero_ff   <= zero_in;
         len_ff    <= len_in;
      end
   end

   // Stored text characters.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

endmodule

`default_nettype wire

>>> sv/fcd_classifier.sv
// Classification of the stored frame text into a command and color values.
`timescale 1ns / 1ps
`default_nettype none

module fcd_classifier (
   input  fcd_pkg::frame_view_type view,
   output fcd_pkg::result_type     result
);
   import fcd_pkg::*;

   logic                 len_word;
   logic                 len_rgb;
   logic                 all_digits;
   logic                 rgb_ok;
   logic [9:0]           color [3];
   logic [LEN_EXT_W-1:0] len_ext;

   function automatic logic word_is(input logic [HEAD_LEN-1:0][7:0] h,
                                    input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
      return (h[0] == a) && (h[1] == b) && (h[2] == c);
   endfunction

   assign len_word = (view.text_len == COUNT_W'(WORD_LEN));
   assign len_rgb  = (view.text_len == COUNT_W'(RGB_LEN));

   // Digit check and three-digit values; an ASCII digit carries its value in
   // the low nibble.
   always_comb begin
      all_digits = 1'b1;
      for (int i = WORD_LEN; i < RGB_LEN; i++) begin
         if (view.head[i] < CHAR_DIG0 || view.head[i] > CHAR_DIG9) begin
            all_digits = 1'b0;
         end
      end
      for (int k = 0; k < 3; k++) begin
         color[k] = 10'(view.head[WORD_LEN + 3 * k][3:0]) * 10'd100
                  + 10'(view.head[WORD_LEN + 3 * k + 1][3:0]) * 10'd10
                  + 10'(view.head[WORD_LEN + 3 * k + 2][3:0]);
      end
   end

   assign rgb_ok = len_rgb && word_is(view.head, CHAR_R, CHAR_G, CHAR_B) && all_digits
                   && (color[0] <= 10'(COLOR_MAX)) && (color[1] <= 10'(COLOR_MAX))
                   && (color[2] <= 10'(COLOR_MAX));

   assign len_ext = LEN_EXT_W'(view.text_len);

   // Commands are checked in priority order.
   always_comb begin
      if (len_word && word_is(view.head, CHAR_A, CHAR_L, CHAR_T)) begin
         result.command = CMD_ALT;
      end else if (len_word && word_is(view.head, CHAR_P, CHAR_E, CHAR_S)) begin
         result.command = CMD_PES;
      end else if (rgb_ok) begin
         result.command = CMD_RGB;
      end else if (len_word && word_is(view.head, CHAR_R, CHAR_G, CHAR_DIG1)) begin
         result.command = CMD_RGB_ON;
      end else if (len_word && word_is(view.head, CHAR_R, CHAR_G, CHAR_DIG0)) begin
         result.command = CMD_RGB_OFF;
      end else if (len_word && word_is(view.head, CHAR_N, CHAR_E, CHAR_DIG1)) begin
         result.command = CMD_NEON_ON;
      end else if (len_word && word_is(view.head, CHAR_N, CHAR_E, CHAR_DIG0)) begin
         result.command = CMD_NEON_OFF;
      end else if (view.text_len != '0 && view.head[0] == CHAR_F) begin
         result.command = CMD_FORWARD;
      end else begin
         result.command = CMD_UNKNOWN;
      end
      result.red   = rgb_ok ? color[0][7:0] : 8'd0;
      result.green = rgb_ok ? color[1][7:0] : 8'd0;
      result.blue  = rgb_ok ? color[2][7:0] : 8'd0;
      // The reported length saturates.
      result.text_length = (len_ext > LEN_EXT_W'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                           : len_ext[LEN_W-1:0];
   end

endmodule

`default_nettype wire

>>> sv/framed_command_decoder.sv
// Top level of the framed command decoder.
// Usage:
//   The req_chan channel carries one received character per word. A '#' opens
//   a frame, a '$' inside an open frame closes it, and each close gives one
//   word on rsp_chan with the command code, the three color values (nonzero
//   only for an RGB command) and the saturated text length. Characters outside
//   a frame, and frames that run past the size limit, give no word.
//   Path: the '$' word waits in the input register until the result register
//   can take a word; the result word then shows on rsp_chan from that register.
//   Throughput: one word per cycle while rsp_chan takes its words; the frame
//   state updates in a single pass from the input register, and the result
//   register takes the word classified from that state.
//   Stall: while rsp_chan holds a word that is not taken, its payload stays
//   put; the input register still fills, and req_chan.ready falls only once
//   both registers are occupied, and then it follows rsp_chan.ready directly.
//   Reset: synchronous, active high; it closes any frame and empties both
//   registers, so no result word is pending afterward.
`timescale 1ns / 1ps
`default_nettype none

module framed_command_decoder (
   input  logic  clock,
   input  logic  reset,
   fcd_req_if.sink   req_chan,
   fcd_rsp_if.source rsp_chan
);
   import fcd_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           out_valid_ff, out_valid_in;
   result_type     out_word_ff, out_word_in;
   logic           advance;
   logic           step;
   logic           close;
   frame_view_type view;
   result_type     result;

   // The input register moves on whenever the result register can take a word.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   fcd_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .view    (view),
      .close   (close)
   );

   fcd_classifier u_classifier (
      .view   (view),
      .result (result)
   );

   // Next values of the input and result registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         if (req_chan.valid) begin
            in_byte_in = req_chan.rx_byte;
         end
      end
      if (advance) begin
         out_valid_in = step && close;
         if (step && close) begin
            out_word_in = result;
         end
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.command     = out_word_ff.command;
   assign rsp_chan.red         = out_word_ff.red;
   assign rsp_chan.green       = out_word_ff.green;
   assign rsp_chan.blue        = out_word_ff.blue;
   assign rsp_chan.text_length = out_word_ff.text_length;

endmodule

`default_nettype wire

>>> sv/fcd_checker.sv
// Port-level checker for the framed command decoder and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "framed_command_decoder_defines.svh"

module fcd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [7:0]              rx_byte,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [3:0]              command,
   input logic [7:0]              red,
   input logic [7:0]              green,
   input logic [7:0]              blue,
   input logic [fcd_pkg::LEN_W-1:0] text_length
);
   import fcd_pkg::*;

   logic              dollar_taken;
   logic              rsp_stall;
   logic [LEN_W+27:0] rsp_word;
   logic              non_rgb;
   logic              is_rgb;
   logic              colors_zero;
   logic              rgb_len_ok;

   assign dollar_taken = req_valid && req_ready && (rx_byte == CHAR_DOLLAR);
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_word     = {command, red, green, blue, text_length};
   assign is_rgb       = (command == CMD_RGB);
   assign non_rgb      = !is_rgb;
   assign colors_zero  = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);
   assign rgb_len_ok   = (text_length == LEN_W'(RGB_LEN));

   // A stalled result word keeps its payload.
   `FCD_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stalled word changed")

   // A new result word comes from a '$' accepted through the input and result registers.
   `FCD_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(dollar_taken, 2), "result with no close")

   // Color values are zero unless the command is RGB.
   `FCD_ASSERT_NOW(a_color_zero, rsp_valid && non_rgb, colors_zero, "color set on a non-RGB word")

   // An RGB command always comes from twelve characters of text.
   `FCD_ASSERT_NOW(a_rgb_len, rsp_valid && is_rgb, rgb_len_ok, "RGB word with wrong length")

endmodule

bind framed_command_decoder fcd_checker u_fcd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rx_byte     (req_chan.rx_byte),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .command     (rsp_chan.command),
   .red         (rsp_chan.red),
   .green       (rsp_chan.green),
   .blue        (rsp_chan.blue),
   .text_length (rsp_chan.text_length)
);

`default_nettype wire

>>> tb/framed_command_decoder_test.sv
// Self-checking testbench for the framed command decoder, with its own frame decode model.
`timescale 1ns / 1ps

module framed_command_decoder_test;
   import fcd_pkg::*;

   // Tracks the open frame and predicts the result word that each closing '$' gives.
   class frame_decode_model;
      result_type expected_q[$];
      int         failures;
      bit         frame_open;
      int         stored_bytes;
      bit         text_ended;
      int         text_chars;
      logic [7:0] head [HEAD_LEN];

      function new();
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_open = 0;
         stored_bytes = 0;
         text_ended = 0;
         text_chars = 0;
         foreach (head[i]) head[i] = CHAR_NUL;
      endfunction

      function bit word_is(logic [7:0] a, logic [7:0] b, logic [7:0] c);
         return text_chars == WORD_LEN && head[0] == a && head[1] == b && head[2] == c;
      endfunction

      function int triple_at(int pos);
         return (int'(head[pos]) - int'(CHAR_DIG0)) * 100 +
                (int'(head[pos + 1]) - int'(CHAR_DIG0)) * 10 +
                (int'(head[pos + 2]) - int'(CHAR_DIG0));
      endfunction

      // An RGB text is "RGB" and nine digits, each group of three at most 255.
      function bit rgb_values(output int r, output int g, output int b);
         r = 0;
         g = 0;
         b = 0;
         if (text_chars != RGB_LEN || head[0] != CHAR_R || head[1] != CHAR_G ||
             head[2] != CHAR_B) return 0;
         for (int i = WORD_LEN; i < RGB_LEN; i++)
            if (head[i] < CHAR_DIG0 || head[i] > CHAR_DIG9) return 0;
         r = triple_at(3);
         g = triple_at(6);
         b = triple_at(9);
         return r <= COLOR_MAX && g <= COLOR_MAX && b <= COLOR_MAX;
      endfunction

      // Applies one accepted request word to the frame state.
      function void take_byte(logic [7:0] c);
         cmd_type    cmd;
         int         r, g, b;
         result_type word;
         if (c == CHAR_HASH) begin
            clear_frame();
            frame_open = 1;
            return;
         end
         if (!frame_open) return;

         // A closing '$' classifies the text in a fixed order of checks.
         if (c == CHAR_DOLLAR) begin
            if (word_is(CHAR_A, CHAR_L, CHAR_T)) cmd = CMD_ALT;
            else if (word_is(CHAR_P, CHAR_E, CHAR_S)) cmd = CMD_PES;
            else if (rgb_values(r, g, b)) cmd = CMD_RGB;
            else if (word_is(CHAR_R, CHAR_G, CHAR_DIG1)) cmd = CMD_RGB_ON;
            else if (word_is(CHAR_R, CHAR_G, CHAR_DIG0)) cmd = CMD_RGB_OFF;
            else if (word_is(CHAR_N, CHAR_E, CHAR_DIG1)) cmd = CMD_NEON_ON;
            else if (word_is(CHAR_N, CHAR_E, CHAR_DIG0)) cmd = CMD_NEON_OFF;
            else if (text_chars >= 1 && head[0] == CHAR_F) cmd = CMD_FORWARD;
            else cmd = CMD_UNKNOWN;
            if (cmd != CMD_RGB) begin
               r = 0;
               g = 0;
               b = 0;
            end
            word.command = cmd;
            word.red = 8'(r);
            word.green = 8'(g);
            word.blue = 8'(b);
            word.text_length = LEN_W'((text_chars > LEN_MAX) ? LEN_MAX : text_chars);
            expected_q.push_back(word);
            clear_frame();
            return;
         end

         // Bytes after the first zero still count toward the size limit.
         if (stored_bytes < FRAME_CAP - 1) begin
            if (!text_ended) begin
               if (c == CHAR_NUL) begin
                  text_ended = 1;
               end else begin
                  if (text_chars < HEAD_LEN) head[text_chars] = c;
                  text_chars++;
               end
            end
            stored_bytes++;
         end else begin
            clear_frame();
         end
      endfunction

      function void check_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      // Compares one accepted result word with the oldest prediction.
      function void check_result(logic [3:0] command, logic [7:0] red, logic [7:0] green,
                                 logic [7:0] blue, logic [LEN_W-1:0] text_length);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result word with no prediction: command %0d, text_length %0d",
                   command, text_length);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         check_field("command", 8'(want.command), 8'(command));
         check_field("red", want.red, red);
         check_field("green", want.green, green);
         check_field("blue", want.blue, blue);
         check_field("text_length", 8'(want.text_length), 8'(text_length));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fcd_req_if req_chan ();
   fcd_rsp_if rsp_chan ();

   framed_command_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frame_decode_model decoder_model;
   logic [7:0]        frame_text[$];
   int                burst_left;
   bit                sender_steady;
   int                bytes_sent;
   int                stall_cycle;
   int                stall_mode;

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // The receiver switches among stall patterns, picking the next one at random.
   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_chan.ready <= ((stall_cycle % 8) < 5);
         default: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Sample both channels at the rising edge: check results, then log requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            decoder_model.check_result(rsp_chan.command, rsp_chan.red, rsp_chan.green,
                                       rsp_chan.blue, rsp_chan.text_length);
         if (req_chan.valid && req_chan.ready) decoder_model.take_byte(req_chan.rx_byte);
      end
   end

   // Sends one word, called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Sends '#', the collected text and '$', then empties the text.
   task automatic send_frame();
      send_byte(CHAR_HASH);
      foreach (frame_text[i]) send_byte(frame_text[i]);
      send_byte(CHAR_DOLLAR);
      frame_text.delete();
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) frame_text.push_back(s[i]);
   endfunction

   function automatic void add_triple(int value);
      frame_text.push_back(8'(CHAR_DIG0 + value / 100));
      frame_text.push_back(8'(CHAR_DIG0 + (value / 10) % 10));
      frame_text.push_back(8'(CHAR_DIG0 + value % 10));
   endfunction

   // Any text byte that neither opens nor closes a frame.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CHAR_HASH || b == CHAR_DOLLAR);
      return b;
   endfunction

   function automatic void add_random_text(int len);
      for (int i = 0; i < len; i++) frame_text.push_back(text_byte());
   endfunction

   function automatic string command_word(int k);
      case (k)
         0: return "ALT";
         1: return "PES";
         2: return "RG1";
         3: return "RG0";
         4: return "NE1";
         default: return "NE0";
      endcase
   endfunction

   // One random frame, mostly well formed, sometimes broken, long or plain noise.
   task automatic random_frame();
      int         kind;
      int         len;
      logic [7:0] b;
      kind = $urandom_range(0, 19);
      case (kind)
         0, 1, 2, 3, 4, 5: begin
            add_text(command_word($urandom_range(0, 5)));
            // Sometimes a near miss: an extra character, a wrong last one, or one too few.
            case ($urandom_range(0, 7))
               0: frame_text.push_back(text_byte());
               1: frame_text[2] = text_byte();
               2: void'(frame_text.pop_back());
               default: ;
            endcase
         end
         6, 7: begin
            add_text("RGB");
            repeat (3) add_triple(($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                             : $urandom_range(0, 255));
         end
         8: begin
            add_text("RGB");
            repeat (3) add_triple($urandom_range(0, 999));
         end
         9: begin
            add_text("RGB");
            len = $urandom_range(0, 12);
            repeat (len) frame_text.push_back(8'(CHAR_DIG0 + $urandom_range(0, 9)));
            if (len > 0 && $urandom_range(0, 1) == 1)
               frame_text[$urandom_range(3, 2 + len)] = text_byte();
         end
         10, 11: begin
            frame_text.push_back(CHAR_F);
            add_random_text($urandom_range(0, 20));
         end
         12, 13: begin
            len = $urandom_range(0, 14);
            for (int i = 0; i < len; i++)
               frame_text.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                               : text_byte());
         end
         14: begin
            // Text cut short by a zero byte, with trailing bytes that do not count.
            if ($urandom_range(0, 1) == 1) add_text(command_word($urandom_range(0, 5)));
            else add_random_text($urandom_range(0, 4));
            frame_text.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 5)) frame_text.push_back(8'($urandom_range(0, 255)));
         end
         15: begin
            // A second '#' restarts the frame that is open.
            add_random_text($urandom_range(0, 6));
            frame_text.push_back(CHAR_HASH);
            add_text(command_word($urandom_range(0, 5)));
         end
         16: begin
            // Noise outside any frame, stray '$' included.
            repeat ($urandom_range(1, 6)) begin
               do b = 8'($urandom_range(0, 255)); while (b == CHAR_HASH);
               send_byte(b);
            end
            return;
         end
         17: begin
            // Long frames, some around the size limit and some of those with a zero byte anywhere.
            if ($urandom_range(0, 2) == 0) begin
               len = $urandom_range(FRAME_CAP - 8, FRAME_CAP + 7);
               add_random_text(len);
               if ($urandom_range(0, 1) == 1) frame_text[$urandom_range(0, len - 1)] = CHAR_NUL;
            end else begin
               add_random_text($urandom_range(13, 30));
            end
         end
         18: begin
            repeat ($urandom_range(0, 3)) frame_text.push_back(CHAR_NUL);
         end
         default: begin
            add_text("RGB");
            repeat (3) add_triple($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
               frame_text.push_back(CHAR_NUL);
               add_random_text($urandom_range(1, 4));
            end
         end
      endcase
      send_frame();
   endtask

   initial begin
      decoder_model = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      burst_left = 0;
      sender_steady = 0;
      bytes_sent = 0;
      stall_cycle = 0;
      stall_mode = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames: every command, color extremes and the corner cases.
      add_text("ALT");
      send_frame();
      add_text("PES");
      send_frame();
      add_text("RGB000000000");
      send_frame();
      add_text("RGB255255255");
      send_frame();
      add_text("RGB255256000");
      send_frame();
      add_text("RG1");
      send_frame();
      add_text("RG0");
      send_frame();
      add_text("NE1");
      send_frame();
      add_text("NE0");
      send_frame();
      add_text("F");
      send_frame();
      add_text("FORWARD");
      send_frame();
      // Empty text.
      send_frame();
      // A zero byte ends the text, so this is ALT.
      add_text("ALT");
      frame_text.push_back(CHAR_NUL);
      add_text("XY");
      send_frame();
      // A leading zero byte leaves an empty text.
      frame_text.push_back(CHAR_NUL);
      add_text("ALT");
      send_frame();
      add_text("ALTT");
      send_frame();
      add_text("RGB12345678");
      send_frame();
      add_text("RGB12A456789");
      send_frame();
      frame_text.push_back(8'hFF);
      frame_text.push_back(8'h80);
      frame_text.push_back(8'h01);
      frame_text.push_back(8'h7F);
      send_frame();
      // Stray '$' and text outside a frame.
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_A);
      // A restart in the middle of a frame.
      add_text("NE1");
      frame_text.push_back(CHAR_HASH);
      add_text("PES");
      send_frame();
      // The longest frame that still gives a result, then one that is dropped.
      add_random_text(FRAME_CAP - 1);
      send_frame();
      add_random_text(FRAME_CAP);
      send_frame();

      // Random frames until about 500 words have gone in.
      while (bytes_sent < 500) begin
         if ($urandom_range(0, 15) == 0) sender_steady = !sender_steady;
         random_frame();
      end
      req_chan.valid <= 1'b0;

      // Drain, then wait for any stray result word before the final check.
      while (decoder_model.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (decoder_model.expected_q.size() != 0) begin
         $error("%0d predicted result words never arrived", decoder_model.expected_q.size());
         decoder_model.failures++;
      end
      if (decoder_model.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
